[design/kmr_pkg.sv]
// Package for the keyed max-score ranking table: sizes, item types and control structs.
package kmr_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RANK_W = 6;
  localparam int KEY_W = 24;
  localparam int POS_W = 10;
  localparam int SCORE_W = 16;
  localparam int ROT_W = 16;
  localparam int RPT_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int CMP_W = (CNT_W > RPT_W) ? CNT_W : RPT_W;

  localparam logic [POS_W-1:0] TARGET_POS_RST = POS_W'(2);
  localparam logic [RPT_W-1:0] REPORT_CNT_RST = RPT_W'(18);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_POS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_CNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic                      req_type;
    logic [KEY_W-1:0]          name_key;
    logic [POS_W-1:0]          position;
    logic signed [SCORE_W-1:0] score;
    logic [ROT_W-1:0]          rotamer;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic [KEY_W-1:0]          out_key;
    logic [POS_W-1:0]          out_position;
    logic signed [SCORE_W-1:0] out_score;
    logic [ROT_W-1:0]          out_rotamer;
    logic                      overflow;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [POS_W-1:0]          pos;
    logic signed [SCORE_W-1:0] score;
    logic [ROT_W-1:0]          rot;
  } entry_t;

  typedef enum logic [1:0] {
    WR_APPEND,
    WR_UPDATE,
    WR_HOLDER
  } wr_src_t;

  typedef struct packed {
    logic              item_ld;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    wr_src_t           wr_src;
    logic              hold_ld;
    logic              cnt_inc;
    logic              ovf_set;
    logic              tbl_clr;
    logic              out_ld;
    logic [RANK_W-1:0] out_rank;
    logic              out_last;
  } kmr_cmd_t;

  typedef struct packed {
    logic             item_rpt;
    logic             pos_match;
    logic             key_match;
    logic             score_gt;
    logic             swap;
    logic             full;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] rpt_cnt;
    logic             out_free;
  } kmr_stat_t;

endpackage

[design/kmr_datapath.sv]
// Datapath of the ranking table: entry memory, sort holder, counters, config and output register.
module kmr_datapath
  import kmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_data,
  input  kmr_cmd_t              cmd,
  output kmr_stat_t             st,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;
  entry_t holder_r;
  entry_t wr_data;
  in_item_t item_r;
  logic [CNT_W-1:0] count_r;
  logic ovf_r;
  logic [POS_W-1:0] target_pos_r;
  logic [RPT_W-1:0] report_cnt_r;
  logic out_valid_r;
  out_item_t out_data_r;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] rpt_ext;

  always_comb begin
    case (cmd.wr_src)
      WR_APPEND: wr_data = '{key: item_r.name_key, pos: item_r.position,
                             score: item_r.score, rot: item_r.rotamer};
      WR_UPDATE: wr_data = '{key: rd_data_r.key, pos: rd_data_r.pos,
                             score: item_r.score, rot: item_r.rotamer};
      WR_HOLDER: wr_data = holder_r;
      default:   wr_data = holder_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      item_r <= in_data;
    end
    if (cmd.hold_ld) begin
      holder_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      ovf_r        <= 1'b0;
      target_pos_r <= TARGET_POS_RST;
      report_cnt_r <= REPORT_CNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.tbl_clr) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        if (cmd.cnt_inc) begin
          count_r <= count_r + CNT_W'(1);
        end
        if (cmd.ovf_set) begin
          ovf_r <= 1'b1;
        end
      end
      if (cfg_valid && cfg_index == CFG_TARGET_POS) begin
        target_pos_r <= cfg_wdata[POS_W-1:0];
      end
      if (cfg_valid && cfg_index == CFG_REPORT_CNT) begin
        report_cnt_r <= cfg_wdata[RPT_W-1:0];
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r <= '{rank: cmd.out_rank, out_key: rd_data_r.key,
                      out_position: rd_data_r.pos, out_score: rd_data_r.score,
                      out_rotamer: rd_data_r.rot, overflow: ovf_r,
                      last: cmd.out_last};
    end
  end

  assign cnt_ext = CMP_W'(count_r);
  assign rpt_ext = CMP_W'(report_cnt_r);

  always_comb begin
    st.item_rpt  = item_r.req_type;
    st.pos_match = (item_r.position == target_pos_r);
    st.key_match = (rd_data_r.key == item_r.name_key);
    st.score_gt  = ($signed(item_r.score) > $signed(rd_data_r.score));
    st.swap      = ($signed(holder_r.score) < $signed(rd_data_r.score));
    st.full      = (count_r == CNT_W'(TABLE_DEPTH));
    st.count     = count_r;
    st.rpt_cnt   = (cnt_ext < rpt_ext) ? count_r : CNT_W'(rpt_ext);
    st.out_free  = !out_valid_r || !out_stall;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/kmr_ctrl.sv]
// Controller of the ranking table: search, exchange sort and report sequencing.
module kmr_ctrl
  import kmr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  kmr_stat_t st,
  output kmr_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH,
    S_SORT_INIT,
    S_SORT_LOADH,
    S_SORT_CMP,
    S_SORT_WB,
    S_RPT_RD,
    S_RPT_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic k_last;
  logic k_rpt_last;
  logic j_done;

  // Index compares run in count width so a full table still compares cleanly.
  assign k_last     = (CNT_W'(k_r) + CNT_W'(1)) == st.count;
  assign k_rpt_last = (CNT_W'(k_r) + CNT_W'(1)) == st.rpt_cnt;
  assign j_done     = (CNT_W'(j_r) + CNT_W'(2)) == st.count;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    cmd       = '0;
    cmd.wr_src = WR_HOLDER;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        k_nxt = '0;
        if (st.item_rpt) begin
          if (st.rpt_cnt == '0) begin
            cmd.tbl_clr = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_RPT_RD;
          end
        end else if (!st.pos_match) begin
          state_nxt = S_IDLE;
        end else if (st.count == '0) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = '0;
          cmd.wr_src  = WR_APPEND;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = '0;
          state_nxt   = S_SRCH;
        end
      end
      S_SRCH: begin
        if (st.key_match) begin
          if (st.score_gt) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = k_r;
            cmd.wr_src  = WR_UPDATE;
            state_nxt   = S_SORT_INIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (k_last) begin
          if (st.full) begin
            cmd.ovf_set = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = IDX_W'(st.count);
            cmd.wr_src  = WR_APPEND;
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_SORT_INIT;
          end
        end else begin
          k_nxt       = k_r + IDX_W'(1);
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = k_r + IDX_W'(1);
        end
      end
      S_SORT_INIT: begin
        j_nxt = '0;
        if (st.count < CNT_W'(2)) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = '0;
          state_nxt   = S_SORT_LOADH;
        end
      end
      S_SORT_LOADH: begin
        cmd.hold_ld = 1'b1;
        k_nxt       = j_r + IDX_W'(1);
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = j_r + IDX_W'(1);
        state_nxt   = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (st.swap) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = k_r;
          cmd.wr_src  = WR_HOLDER;
          cmd.hold_ld = 1'b1;
        end
        if (k_last) begin
          state_nxt = S_SORT_WB;
        end else begin
          k_nxt       = k_r + IDX_W'(1);
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = k_r + IDX_W'(1);
        end
      end
      S_SORT_WB: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = j_r;
        cmd.wr_src  = WR_HOLDER;
        if (j_done) begin
          state_nxt = S_IDLE;
        end else begin
          j_nxt       = j_r + IDX_W'(1);
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = j_r + IDX_W'(1);
          state_nxt   = S_SORT_LOADH;
        end
      end
      S_RPT_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = k_r;
        state_nxt   = S_RPT_LOAD;
      end
      S_RPT_LOAD: begin
        if (st.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_rank = RANK_W'(k_r) + RANK_W'(1);
          cmd.out_last = k_rpt_last;
          if (k_rpt_last) begin
            cmd.tbl_clr = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_RPT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[design/keyed_max_score_ranking_table.sv]
// Top level of the keyed max-score ranking table.
//
// The block keeps up to TABLE_DEPTH entries, one per key, each holding the best score
// seen for that key together with its rotamer and the position of its first insert;
// the table is kept in descending score order by an exchange sort. One transaction is
// worked on at a time and in_stall stays high until it is done. An insert whose
// position differs from target_position returns to idle after dispatch. A matching
// insert on a table of n entries searches up to n entries for its key through the
// single read port of the entry memory and then, when the table changed, runs a sort
// pass at one compare per cycle. The sort holds entry j in a register and writes
// back at most one entry per compare, so one read and one write port suffice. A
// report reads and loads its results one at a time, waiting while out_stall holds the
// result register, and clears the table and the sticky overflow flag once its last
// result is loaded, or at once when it emits none. The result register decouples the
// output: the next input transaction is taken while the last result of a report is
// still waiting. Configuration writes are always ready and must be issued only while
// the block is idle. There is no clearing pass.
module keyed_max_score_ranking_table
  import kmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  kmr_cmd_t  cmd;
  kmr_stat_t st;

  kmr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  kmr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // A new result only appears while a report transaction is in progress.
  a_out_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while no report was in progress");

  // The sort and the search never read and write the same entry in one cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && cmd.rd_en) |-> (cmd.wr_addr != cmd.rd_addr))
    else $error("entry memory read and written at the same address");

  // The fill count never runs past the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // An append only happens on a table that still has room.
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !st.full)
    else $error("entry appended to a full table");

endmodule

[verif/kmr_tb_pkg.sv]
// Request codes shared by the ranking table testbench modules.
package kmr_tb_pkg;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REPORT = 1'b1
  } req_kind_t;

endpackage

[verif/kmr_ranking_checker.sv]
// Checker that predicts the ranking table's reports and compares every result transaction.
module kmr_ranking_checker
  import kmr_pkg::*;
  import kmr_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending_cnt,
  output int                    mismatches,
  output int                    results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the table, its flags and the two registers.
  entry_t           slots [TABLE_DEPTH];
  int               fill;
  logic             ovf;
  logic [POS_W-1:0] tgt;
  logic [RPT_W-1:0] rpt_lim;

  // Ranked entries still owed by the block, oldest first.
  out_item_t due_ranks[$];

  int fails = 0;
  int n_seen = 0;

  task automatic log_error(string msg);
    if (fails < 100) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    fails++;
  endtask

  task automatic check_field(string name, int rank, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      log_error($sformatf("rank %0d %s: got %0h, expected %0h", rank, name, got, want));
    end
  endtask

  // Keeps the best score per key, appends new keys or flags overflow, then re-sorts.
  task automatic absorb_record(in_item_t it);
    bit     hit;
    entry_t tmp;
    hit = 1'b0;
    for (int k = 0; k < fill; k++) begin
      if (slots[k].key == it.name_key) begin
        if ($signed(slots[k].score) < $signed(it.score)) begin
          slots[k].score = it.score;
          slots[k].rot   = it.rotamer;
        end
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (fill >= TABLE_DEPTH) begin
        ovf = 1'b1;
      end else begin
        slots[fill].key   = it.name_key;
        slots[fill].pos   = it.position;
        slots[fill].score = it.score;
        slots[fill].rot   = it.rotamer;
        fill++;
      end
    end
    // Exchange sort in the block's exact visiting order, so equal scores land alike.
    for (int j = 0; j < fill; j++) begin
      for (int k = j + 1; k < fill; k++) begin
        if ($signed(slots[j].score) < $signed(slots[k].score)) begin
          tmp      = slots[j];
          slots[j] = slots[k];
          slots[k] = tmp;
        end
      end
    end
  endtask

  // Queues the top entries of the table, then empties it and drops the overflow flag.
  task automatic issue_ranking();
    int        n;
    out_item_t r;
    n = (fill < int'(rpt_lim)) ? fill : int'(rpt_lim);
    if (n > TABLE_DEPTH) begin
      n = TABLE_DEPTH;
    end
    for (int k = 0; k < n; k++) begin
      r.rank         = RANK_W'(k + 1);
      r.out_key      = slots[k].key;
      r.out_position = slots[k].pos;
      r.out_score    = slots[k].score;
      r.out_rotamer  = slots[k].rot;
      r.overflow     = ovf;
      r.last         = (k == n - 1);
      due_ranks.push_back(r);
    end
    fill = 0;
    ovf  = 1'b0;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    n_seen++;
    if (due_ranks.size() == 0) begin
      log_error($sformatf("result with nothing expected: rank %0d key %0h",
                          got.rank, got.out_key));
      return;
    end
    want = due_ranks.pop_front();
    check_field("rank",     want.rank, got.rank,         want.rank);
    check_field("key",      want.rank, got.out_key,      want.out_key);
    check_field("position", want.rank, got.out_position, want.out_position);
    check_field("score",    want.rank, got.out_score,    want.out_score);
    check_field("rotamer",  want.rank, got.out_rotamer,  want.out_rotamer);
    check_field("overflow", want.rank, got.overflow,     want.overflow);
    check_field("last",     want.rank, got.last,         want.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill    = 0;
      ovf     = 1'b0;
      tgt     = TARGET_POS_RST;
      rpt_lim = REPORT_CNT_RST;
      due_ranks.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TARGET_POS) begin
          tgt = cfg_wdata[POS_W-1:0];
        end else if (cfg_index == CFG_REPORT_CNT) begin
          rpt_lim = cfg_wdata[RPT_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.req_type == REQ_REPORT) begin
          issue_ranking();
        end else if (in_data.position == tgt) begin
          absorb_record(in_data);
        end
      end
    end
    pending_cnt  <= due_ranks.size();
    mismatches   <= fails;
    results_seen <= n_seen;
  end

endmodule

[verif/tb_keyed_max_score_ranking_table.sv]
// Top of the ranking table testbench: clock, reset, stimulus, flow control and verdict.
module tb_keyed_max_score_ranking_table;
  timeunit 1ns;
  timeprecision 1ps;
  import kmr_pkg::*;
  import kmr_tb_pkg::*;

  // The slowest legal run is a few hundred inserts on a full table, plus receiver
  // stalls on up to 32 results per report and the long hold-off below, so this
  // limit only trips when the block has hung.
  localparam int CYCLE_LIMIT = 3_000_000;
  // A full-table insert produces no result but keeps the block busy with its search
  // and sort, so settle() adds this margin at every idle point.
  localparam int SETTLE_CYCLES = 800;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 1500;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int pending_cnt;
  int mismatches;
  int results_seen;

  // Flow control knobs. The sender percentage is only used by the stimulus
  // process; the receiver percentage and hold requests cross into the receiver
  // process and are therefore written with nonblocking assignments.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  // Run bookkeeping. live_items counts every transaction the block has taken,
  // inserts at any position as well as reports.
  logic [POS_W-1:0] cur_target;
  int live_items = 0;
  int n_inserts = 0;
  int n_reports = 0;
  int n_settings = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  keyed_max_score_ranking_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  kmr_ranking_checker ranking_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .pending_cnt  (pending_cnt),
    .mismatches   (mismatches),
    .results_seen (results_seen)
  );

  // Receiver. A new hold request starts a long stretch of stall, counted here,
  // during which the sender keeps offering transactions; otherwise the stall is
  // random at the current percentage.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog. It is the only other place where the run can end.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_cnt, pending_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_item_t record(logic [KEY_W-1:0] key, logic [POS_W-1:0] pos,
                                      logic signed [SCORE_W-1:0] score,
                                      logic [ROT_W-1:0] rot);
    in_item_t it;
    it.req_type = REQ_INSERT;
    it.name_key = key;
    it.position = pos;
    it.score    = score;
    it.rotamer  = rot;
    return it;
  endfunction

  // A report carries random payload fields, which the block must ignore.
  function automatic in_item_t ranking_req();
    logic [95:0] junk;
    in_item_t    it;
    junk        = {$urandom, $urandom, $urandom};
    it          = junk[$bits(in_item_t)-1:0];
    it.req_type = REQ_REPORT;
    return it;
  endfunction

  // Mostly short ASCII names from a small alphabet so that keys repeat, with
  // some one-letter names and some fully random 24-bit keys.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: return KEY_W'($urandom);
      1: return {8'(8'h41 + $urandom_range(0, 7)), 16'h0000};
      default: return {8'(8'h41 + $urandom_range(0, 7)), 8'(8'h41 + $urandom_range(0, 7)),
                       8'(8'h41 + $urandom_range(0, 7))};
    endcase
  endfunction

  // Scores lean on the extremes and on a narrow band that forces ties.
  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return SCORE_W'($urandom_range(0, 3));
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  // Offers one transaction after a random number of idle cycles and returns at
  // the edge where it is taken. Valid stays high when no gap follows, so it is
  // never lowered and raised within the same time step.
  task automatic offer(in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    live_items++;
    if (it.req_type == REQ_REPORT) begin
      n_reports++;
    end else begin
      n_inserts++;
    end
  endtask

  // Brings the block to idle: every expected result delivered, then enough
  // extra cycles for any insert still being sorted.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back with the write valid held high.
  task automatic set_config(int tgt, int rc);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TARGET_POS;
    cfg_wdata <= CFG_DATA_W'(tgt);
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_index <= CFG_REPORT_CNT;
    cfg_wdata <= CFG_DATA_W'(rc);
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    cur_target = POS_W'(tgt);
    n_settings++;
  endtask

  // One well-formed sequence: a batch of inserts drawn from a key pool, then a
  // report. Wide rounds use more distinct keys than the table holds, so the
  // table can fill and the overflow flag show up on the report. Narrow rounds
  // use a small pool so that keys repeat and scores get replaced or kept.
  task automatic run_round(int n_ins, bit wide, bit hold_at_end);
    logic [KEY_W-1:0] pool [64];
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    int               n_keys;
    n_keys = wide ? $urandom_range(33, 40) : $urandom_range(1, n_ins);
    for (int i = 0; i < n_keys; i++) begin
      pool[i] = wide ? {16'($urandom), 8'(i)} : pick_key();
    end
    for (int i = 0; i < n_ins; i++) begin
      // A stray report now and then cuts a sequence short.
      if (!wide && $urandom_range(99) < 3) begin
        offer(ranking_req());
      end
      key = (i < n_keys) ? pool[i] : pool[$urandom_range(0, n_keys - 1)];
      pos = ($urandom_range(99) < 88) ? cur_target : POS_W'($urandom);
      offer(record(key, pos, rand_score(), ROT_W'($urandom)));
    end
    if (hold_at_end) begin
      hold_asks <= hold_asks + 1;
    end
    offer(ranking_req());
    // Sometimes a second report right away, which finds the table empty.
    if ($urandom_range(99) < 15) begin
      offer(ranking_req());
    end
  endtask

  // Rounds until the live transaction count reaches the given mark. With
  // pressure set, the first round is a wide one and its report meets the long
  // receiver hold-off while the next round is already being offered.
  task automatic run_phase(int end_count, bit pressure);
    bit first;
    first = pressure;
    while (live_items < end_count) begin
      if (first) begin
        run_round(44, 1'b1, 1'b1);
        first = 1'b0;
      end else if ($urandom_range(99) < 8) begin
        run_round($urandom_range(41, 48), 1'b1, 1'b0);
      end else begin
        run_round($urandom_range(1, 14), 1'b0, 1'b0);
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_TARGET_POS;
    cfg_wdata     <= '0;
    recv_idle_pct <= 53;
    send_idle_pct = 24;
    cur_target    = TARGET_POS_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings (target 2, report size 18).
    // Field extremes, a lower and an equal score that must not replace the
    // stored one, an insert at another position that must be ignored, a real
    // replacement, a tie on score, then a report and a report on an empty table.
    offer(record(24'h414243, 10'd2, 16'sh7FFF, 16'hFFFF));
    offer(record(24'hFFFFFF, 10'd2, 16'sh8000, 16'h0000));
    offer(record(24'h000000, 10'd2, 16'sh0000, 16'h1234));
    offer(record(24'h414243, 10'd2, 16'sh0064, 16'h0001));
    offer(record(24'h000000, 10'd2, 16'sh0000, 16'h0005));
    offer(record(24'h000000, 10'd1023, 16'sh01F4, 16'h0009));
    offer(record(24'h000000, 10'd2, 16'sh0001, 16'h0007));
    offer(record(24'h585900, 10'd2, 16'sh0001, 16'h0008));
    offer(ranking_req());
    offer(ranking_req());
    // This entry stays in the table across the register change below.
    offer(record(24'h510000, 10'd2, -16'sd5, 16'h0003));

    // Highest target and a report size of zero. The surviving key gets a better
    // score at the new position but keeps the position it was first stored
    // with; the report then emits nothing yet still clears the table.
    settle();
    set_config(1023, 0);
    offer(record(24'h510000, 10'd1023, 16'sh0028, 16'hBEEF));
    offer(record(24'h123456, 10'd1023, -16'sd1, 16'h0F0F));
    offer(ranking_req());
    offer(ranking_req());

    // Lowest target and a report size of one: a single result marked last.
    settle();
    set_config(0, 1);
    offer(record(24'hA5A5A5, 10'd0, 16'sh0002, 16'h5555));
    offer(record(24'h5A5A5A, 10'd0, 16'sh0003, 16'hAAAA));
    offer(ranking_req());

    // Random part. First phase: the full report size, light sender gaps and a
    // busy receiver.
    settle();
    set_config($urandom_range(0, 1023), 32);
    run_phase(140, 1'b0);

    // Second phase: roles of the two sides swapped, a random report size.
    settle();
    send_idle_pct = 53;
    recv_idle_pct <= 24;
    set_config($urandom_range(0, 1023), $urandom_range(1, 31));
    run_phase(260, 1'b0);

    // Third phase: no idling on either side, plus the long receiver hold-off.
    settle();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    set_config($urandom_range(0, 1023), 31);
    run_phase(380, 1'b1);

    settle();
    $display("Covered %0d inserts and %0d reports under %0d register settings.",
             n_inserts, n_reports, n_settings);
    $display("%0d ranked results were compared against the prediction.", results_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
